// File: hw/rtl/rhbp_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV byte pack: shared package
// Types, widths and default depths used by the converter's modules.
// ----------------------------------------------------------------------------
package rhbp_pkg;

    // Default queue depths. The result queue must cover the divider pipeline
    // plus a little slack so that a steady stream never waits on credits.
    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 16;

    // Quotient bits produced by the divider, one per pipeline step.
    localparam int QUO_W = 9;

    // Hue numerator is hue_degrees * delta * 32, below 360 * 255 * 32.
    localparam int HUE_NUM_W = 22;
    // Hue denominator is 45 * delta.
    localparam int HUE_DEN_W = 14;
    // Saturation numerator is delta * 256.
    localparam int SAT_NUM_W = 16;

    // One classified pixel, as handed from the front end to the divider.
    typedef struct packed {
        logic [HUE_NUM_W-1:0] hue_num;
        logic [HUE_DEN_W-1:0] hue_den;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [7:0]           sat_den;
        logic                 grey;
        logic                 black;
        logic [7:0]           bright;
    } cls_t;

    // One step of the divider pipeline.
    typedef struct packed {
        logic [HUE_NUM_W-1:0] rem_h;
        logic [HUE_DEN_W-1:0] den_h;
        logic [QUO_W-1:0]     quo_h;
        logic [SAT_NUM_W-1:0] rem_s;
        logic [7:0]           den_s;
        logic [QUO_W-1:0]     quo_s;
        logic                 grey;
        logic                 black;
        logic [7:0]           bright;
    } div_t;

    // One finished result item.
    typedef struct packed {
        logic [7:0] bright;
        logic [7:0] sat;
        logic [7:0] hue;
    } res_t;

endpackage

// File: hw/rtl/rhbp_fifo.sv
// ----------------------------------------------------------------------------
// RGB to HSV byte pack: small queue
// A register-array queue with full and empty flags and a combinational head.
// ----------------------------------------------------------------------------
module rhbp_fifo #(
    parameter int DEPTH = rhbp_pkg::MID_DEPTH_DEF,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hw/rtl/rhbp_front.sv
// ----------------------------------------------------------------------------
// RGB to HSV byte pack: front end
// Finds the maximum channel and builds the hue and saturation fractions.
// ----------------------------------------------------------------------------
module rhbp_front (
    input  logic [7:0]     red,
    input  logic [7:0]     green,
    input  logic [7:0]     blue,
    output rhbp_pkg::cls_t cls
);

    logic               red_max;
    logic               green_max;
    logic [7:0]         mx;
    logic [7:0]         mn;
    logic [7:0]         delta;
    logic signed [8:0]  diff;
    logic signed [17:0] base;
    logic [16:0]        offs;
    logic [16:0]        wrap;
    logic signed [17:0] num;
    logic signed [17:0] num_w;

    // Red wins ties over green, and green over blue.
    assign red_max   = (red >= green) && (red >= blue);
    assign green_max = !red_max && (green >= blue);

    always_comb
    begin
        if (red_max)
        begin
            mx   = red;
            diff = $signed({1'b0, green}) - $signed({1'b0, blue});
            offs = '0;
        end
        else if (green_max)
        begin
            mx   = green;
            diff = $signed({1'b0, blue}) - $signed({1'b0, red});
            offs = 17'(delta) * 17'd120;
        end
        else
        begin
            mx   = blue;
            diff = $signed({1'b0, red}) - $signed({1'b0, green});
            offs = 17'(delta) * 17'd240;
        end
    end

    always_comb
    begin
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
    end

    assign delta = mx - mn;
    assign base  = 18'(diff) * 18'sd60;
    assign num   = base + $signed({1'b0, offs});
    assign wrap  = 17'(delta) * 17'd360;
    assign num_w = num[17] ? (num + $signed({1'b0, wrap})) : num;

    // Hue byte is floor(num * 32 / (45 * delta)); saturation is delta * 256 / max.
    always_comb
    begin
        cls.hue_num = {num_w[16:0], 5'b00000};
        cls.hue_den = 14'(delta) * 14'd45;
        cls.sat_num = {delta, 8'h00};
        cls.sat_den = mx;
        cls.grey    = (delta == 8'd0);
        cls.black   = (mx == 8'd0);
        cls.bright  = mx;
    end

endmodule

// File: hw/rtl/rhbp_back.sv
// ----------------------------------------------------------------------------
// RGB to HSV byte pack: back end
// Credit-gated issue into a pipelined restoring divider, one quotient bit
// per stage for hue and saturation side by side.
// ----------------------------------------------------------------------------
module rhbp_back #(
    parameter int OUT_DEPTH = rhbp_pkg::OUT_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rhbp_pkg::cls_t head,
    input  logic           head_valid,
    output logic           issue,
    input  logic           pop_done,
    output logic           res_valid,
    output rhbp_pkg::res_t res
);

    localparam int QW  = rhbp_pkg::QUO_W;
    localparam int HNW = rhbp_pkg::HUE_NUM_W;
    localparam int SNW = rhbp_pkg::SAT_NUM_W;
    localparam int CW  = $clog2(OUT_DEPTH + 1);

    // Credits count items issued and not yet taken from the result queue,
    // so the result queue can never overflow.
    logic [CW-1:0]  credit_reg, credit_next;
    logic           vld_reg [QW+1];
    rhbp_pkg::div_t stg_reg [QW+1];
    rhbp_pkg::div_t stg_next [QW+1];

    assign issue = head_valid && (credit_reg < CW'(OUT_DEPTH));

    always_comb
    begin
        credit_next = credit_reg;
        if (issue && !pop_done)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (pop_done && !issue)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_comb
    begin
        stg_next[0].rem_h  = head.hue_num;
        stg_next[0].den_h  = head.hue_den;
        stg_next[0].quo_h  = '0;
        stg_next[0].rem_s  = head.sat_num;
        stg_next[0].den_s  = head.sat_den;
        stg_next[0].quo_s  = '0;
        stg_next[0].grey   = head.grey;
        stg_next[0].black  = head.black;
        stg_next[0].bright = head.bright;
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_step
        localparam int SH = QW - 1 - j;
        logic [HNW-1:0] trial_h;
        logic [SNW-1:0] trial_s;

        assign trial_h = HNW'(stg_reg[j].den_h) << SH;
        assign trial_s = SNW'(stg_reg[j].den_s) << SH;

        always_comb
        begin
            stg_next[j+1] = stg_reg[j];
            if (stg_reg[j].rem_h >= trial_h)
            begin
                stg_next[j+1].rem_h     = stg_reg[j].rem_h - trial_h;
                stg_next[j+1].quo_h[SH] = 1'b1;
            end
            if (stg_reg[j].rem_s >= trial_s)
            begin
                stg_next[j+1].rem_s     = stg_reg[j].rem_s - trial_s;
                stg_next[j+1].quo_s[SH] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            stg_reg[j+1] <= stg_next[j+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            credit_reg <= credit_next;
            vld_reg[0] <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_reg[0] <= stg_next[0];
    end

    // A grey pixel has no hue and a black one no saturation; a full
    // saturation quotient of 256 clips to 255.
    assign res_valid = vld_reg[QW];

    always_comb
    begin
        res.bright = stg_reg[QW].bright;
        res.hue    = stg_reg[QW].grey ? 8'd0 : stg_reg[QW].quo_h[7:0];
        if (stg_reg[QW].black)
        begin
            res.sat = 8'd0;
        end
        else if (stg_reg[QW].quo_s[QW-1])
        begin
            res.sat = 8'hFF;
        end
        else
        begin
            res.sat = stg_reg[QW].quo_s[7:0];
        end
    end

endmodule

// File: hw/rtl/rgb_to_hsv_byte_pack.sv
// ----------------------------------------------------------------------------
// RGB to HSV byte pack: top level
// Converts one 8-bit RGB pixel into hue, saturation and brightness bytes.
// ----------------------------------------------------------------------------
// An accepted item passes through the middle queue, the divider's input
// register, its nine steps and then the result queue to the result ports.
// Throughput: one item per cycle, sustained while pop keeps up.
// Reset: rst_n clears both queues, the divider's valid bits and the credit
// count at once; full and empty read low and high right after reset.
// ----------------------------------------------------------------------------
//
// The front end finds the largest channel, picks the hue sector (red wins
// ties over green, green over blue) and forms two fractions: hue as
// (hue_degrees * delta * 32) / (45 * delta) and saturation as
// (delta * 256) / max. Each classified item goes into a short middle queue.
//
// The back end takes items from the middle queue into a restoring divider
// that produces one quotient bit per pipeline stage for both fractions at
// once. An item only enters the divider when the result queue is sure to
// have room for it, so the divider never stalls; the credit count covers
// items in flight and items waiting in the result queue. Either side can
// therefore stall on its own without losing or repeating an item.
//
module rgb_to_hsv_byte_pack #(
    parameter int MID_DEPTH = rhbp_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = rhbp_pkg::OUT_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  hue_byte,
    output logic [7:0]  sat_byte,
    output logic [7:0]  bright_byte,
    output logic [23:0] packed_hsb
);

    localparam int CLS_W = $bits(rhbp_pkg::cls_t);
    localparam int RES_W = $bits(rhbp_pkg::res_t);

    rhbp_pkg::cls_t   cls;
    logic [CLS_W-1:0] mid_head_bits;
    rhbp_pkg::cls_t   mid_head;
    logic             mid_empty;
    logic             issue;
    logic             res_valid;
    rhbp_pkg::res_t   res;
    logic [RES_W-1:0] out_head_bits;
    rhbp_pkg::res_t   out_head;
    logic             out_full;
    logic             push_ok;
    logic             pop_ok;

    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;

    rhbp_front u_front (
        .red   (red),
        .green (green),
        .blue  (blue),
        .cls   (cls)
    );

    rhbp_fifo #(
        .DEPTH (MID_DEPTH),
        .WIDTH (CLS_W)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push_ok),
        .wr_data (cls),
        .full    (full),
        .rd_en   (issue),
        .rd_data (mid_head_bits),
        .empty   (mid_empty)
    );

    assign mid_head = rhbp_pkg::cls_t'(mid_head_bits);

    rhbp_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (mid_head),
        .head_valid (!mid_empty),
        .issue      (issue),
        .pop_done   (pop_ok),
        .res_valid  (res_valid),
        .res        (res)
    );

    // The credit scheme keeps this queue from ever filling past its depth,
    // so its full flag is only there for completeness of the queue itself.
    rhbp_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH (RES_W)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid && !out_full),
        .wr_data (res),
        .full    (out_full),
        .rd_en   (pop_ok),
        .rd_data (out_head_bits),
        .empty   (empty)
    );

    assign out_head    = rhbp_pkg::res_t'(out_head_bits);
    assign hue_byte    = out_head.hue;
    assign sat_byte    = out_head.sat;
    assign bright_byte = out_head.bright;
    assign packed_hsb  = {out_head.bright, out_head.sat, out_head.hue};

endmodule

// File: hw/rtl/rhbp_checker.sv
// ----------------------------------------------------------------------------
// RGB to HSV byte pack: port checker
// Checks result consistency and queue behavior seen at the top level's ports.
// ----------------------------------------------------------------------------
module rhbp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pop,
    input logic        empty,
    input logic [7:0]  hue_byte,
    input logic [7:0]  sat_byte,
    input logic [7:0]  bright_byte,
    input logic [23:0] packed_hsb
);

    // No result can be waiting at the first edge after reset.
    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("result queue not empty after reset");

    // The packed word matches the three separate bytes whenever a result waits.
    a_packed_match: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (packed_hsb == {bright_byte, sat_byte, hue_byte}))
        else $error("packed word does not match the bytes");

    // A black pixel has neither hue nor saturation.
    a_black_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (bright_byte == 8'd0)) |-> ((sat_byte == 8'd0) && (hue_byte == 8'd0)))
        else $error("black pixel with nonzero hue or saturation");

    // Zero saturation only arises from a grey pixel, whose hue is zero.
    a_grey_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (sat_byte == 8'd0)) |-> (hue_byte == 8'd0))
        else $error("grey pixel with nonzero hue");

    // A result that is not taken stays put.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(packed_hsb)))
        else $error("waiting result changed or vanished");

endmodule

bind rgb_to_hsv_byte_pack rhbp_checker u_rhbp_checker (.*);
